FILE: rtl/core/mbcc_pkg.sv
// Package for the mouse button click classifier.
// Holds the lane count, field widths, state codes, register indexes and the
// per-button result struct. No dependencies.
package mbcc_pkg;

   // Number of physical buttons the design is built for; lanes are capped at eight.
   localparam int BUTTONS   = 8;
   localparam int NUM_LANES = (BUTTONS > 8) ? 8 : BUTTONS;
   localparam int LANE_IDX_W = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;

   localparam int LEVEL_W = 8;
   localparam int TIME_W  = 16;
   localparam int INDEX_W = 3;
   localparam int STATE_W = 2;
   localparam int CSR_ADDR_W = 2;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // Click state codes.
   localparam logic [STATE_W-1:0] ST_UP       = 2'd0;
   localparam logic [STATE_W-1:0] ST_DOUBLE   = 2'd1;
   localparam logic [STATE_W-1:0] ST_DRAGGED  = 2'd2;
   localparam logic [STATE_W-1:0] ST_RELEASED = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_DBL_WINDOW = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LONG_TIME  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_LIMIT = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_SUBST = 2'd3;

   // Configuration values seen by every lane.
   typedef struct packed {
      logic [TIME_W-1:0] dbl_window;
      logic [TIME_W-1:0] long_time;
   } lane_cfg_type;

   // What one lane reports for its button in one tick.
   typedef struct packed {
      logic                is_down;
      logic                pressed;
      logic                released;
      logic                double_clicked;
      logic                held_long;
      logic [STATE_W-1:0]  button_state;
      logic [TIME_W-1:0]   held_time;
   } lane_res_type;

endpackage

FILE: rtl/core/mbcc_lane.sv
// One button lane of the click classifier: the per-button timers and flags
// and the classification of one tick. Depends on mbcc_pkg.
module mbcc_lane
   import mbcc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step,        // tick accepted this cycle
   input  logic                now_down,
   input  logic [TIME_W-1:0]   delta,
   input  lane_cfg_type        cfg,
   output lane_res_type        res,
   output logic                dragging
);

   logic                prev_down_ff, prev_down_in;
   logic [TIME_W-1:0]   dbl_timer_ff, dbl_timer_in;
   logic [TIME_W-1:0]   hold_timer_ff, hold_timer_in;
   logic                long_flag_ff, long_flag_in;

   logic [TIME_W-1:0]   dbl_dec;
   logic [TIME_W:0]     hold_sum;
   logic [TIME_W-1:0]   hold_sat;
   logic                press;
   logic                dbl;

   always_comb begin
      dbl_dec  = (dbl_timer_ff > delta) ? (dbl_timer_ff - delta) : '0;
      hold_sum = {1'b0, hold_timer_ff} + {1'b0, delta};
      hold_sat = hold_sum[TIME_W] ? TIME_MAX : hold_sum[TIME_W-1:0];

      if (prev_down_ff) begin
         dbl_timer_in  = cfg.dbl_window;
         hold_timer_in = hold_sat;
         long_flag_in  = long_flag_ff | (hold_sat >= cfg.long_time);
      end else begin
         dbl_timer_in  = dbl_dec;
         hold_timer_in = '0;
         long_flag_in  = 1'b0;
      end
      prev_down_in = now_down;

      press = now_down & ~prev_down_ff;
      // A press can only happen when the button was up, so the timer was not reloaded.
      dbl   = press & (dbl_dec != '0);

      res.is_down        = now_down;
      res.pressed        = press;
      res.released       = ~now_down & prev_down_ff;
      res.double_clicked = dbl;
      res.held_long      = now_down & long_flag_in;
      res.held_time      = hold_timer_in;
      if (now_down) begin
         res.button_state = dbl ? ST_DOUBLE : ST_DRAGGED;
      end else if (prev_down_ff) begin
         res.button_state = ST_RELEASED;
      end else begin
         res.button_state = ST_UP;
      end
      dragging = now_down & ~dbl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_down_ff  <= 1'b0;
         dbl_timer_ff  <= '0;
         hold_timer_ff <= '0;
         long_flag_ff  <= 1'b0;
      end else if (step) begin
         prev_down_ff  <= prev_down_in;
         dbl_timer_ff  <= dbl_timer_in;
         hold_timer_ff <= hold_timer_in;
         long_flag_ff  <= long_flag_in;
      end
   end

endmodule

FILE: rtl/core/mbcc_merge.sv
// Merge and output stage of the click classifier: combines the lane drag
// flags, holds one tick's results and sends them one per cycle while the
// receiver is ready. Depends on mbcc_pkg.
module mbcc_merge
   import mbcc_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,      // tick accepted this cycle
   input  lane_res_type [NUM_LANES-1:0]      lane_res,
   input  logic [NUM_LANES-1:0]              lane_drag,
   output logic                              can_load,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [INDEX_W-1:0]                out_index,
   output lane_res_type                      out_res,
   output logic                              out_any_drag,
   output logic                              out_last
);

   localparam logic [LANE_IDX_W-1:0] LAST_IDX = LANE_IDX_W'(NUM_LANES - 1);

   lane_res_type [NUM_LANES-1:0] bank_ff;
   logic                         any_drag_ff;
   logic                         bank_valid_ff, bank_valid_in;
   logic [LANE_IDX_W-1:0]        idx_ff, idx_in;
   logic                         out_take;

   always_comb begin
      out_take = bank_valid_ff & out_ready;
      out_last = (idx_ff == LAST_IDX);
      can_load = ~bank_valid_ff | (out_take & out_last);

      bank_valid_in = bank_valid_ff;
      idx_in        = idx_ff;
      if (out_take) begin
         if (out_last) begin
            bank_valid_in = 1'b0;
            idx_in        = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (load) begin
         bank_valid_in = 1'b1;
         idx_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         bank_valid_ff <= bank_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bank_ff     <= lane_res;
         any_drag_ff <= |lane_drag;
      end
   end

   assign out_valid    = bank_valid_ff;
   assign out_index    = INDEX_W'(idx_ff);
   assign out_res      = bank_ff[idx_ff];
   assign out_any_drag = any_drag_ff;

endmodule

FILE: rtl/core/mouse_button_click_classifier.sv
// Top level of the mouse button click classifier.
// Depends on mbcc_pkg, mbcc_lane and mbcc_merge.
//
// Usage:
// Each item on the req_ channel is one tick: a mask of button levels and the
// milliseconds elapsed since the previous tick. Elapsed times above the step
// limit register are replaced by the step substitute register.
// For every tick the block returns one item per button on the rsp_ channel,
// in button order, with rsp_tlast set on the item of the highest button.
// All buttons are processed at once by parallel lanes in the cycle the tick
// is accepted; the first result item is valid in the next cycle and the
// remaining ones follow one per cycle while rsp_tready stays high. A new tick
// is accepted in the same cycle the last result item of the previous tick
// is taken, and not before, since the single result buffer holds one tick.
// When the receiver stalls, the current result item holds and req_tready
// stays low until the buffered tick has been drained.
// Reset restores the register defaults (250, 700, 1000, 50) and clears all
// per-button timers and flags; configuration writes take effect at once and
// are expected only while the block is idle.
module mouse_button_click_classifier
   import mbcc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Tick items.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_W-1:0]    req_tdata,   // buttons_down[7:0], elapsed_ms[23:8]
   // Per-button result items.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_W-1:0]    rsp_tdata,   // button_index[2:0], is_down[3],
                                                 // pressed[4], released[5],
                                                 // double_clicked[6], held_long[7],
                                                 // button_state[9:8], held_time[25:10],
                                                 // any_dragging[26], zero[31:27]
   output logic                     rsp_tlast,   // last_of_tick
   // Configuration writes.
   input  logic                     csr_wr_en,
   input  logic [CSR_ADDR_W-1:0]    csr_addr,
   input  logic [TIME_W-1:0]        csr_wdata
);

   // Configuration registers.
   logic [TIME_W-1:0] dbl_window_ff;
   logic [TIME_W-1:0] long_time_ff;
   logic [TIME_W-1:0] step_limit_ff;
   logic [TIME_W-1:0] step_subst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dbl_window_ff <= TIME_W'(250);
         long_time_ff  <= TIME_W'(700);
         step_limit_ff <= TIME_W'(1000);
         step_subst_ff <= TIME_W'(50);
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_DBL_WINDOW: dbl_window_ff <= csr_wdata;
            CSR_LONG_TIME:  long_time_ff  <= csr_wdata;
            CSR_STEP_LIMIT: step_limit_ff <= csr_wdata;
            CSR_STEP_SUBST: step_subst_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Tick decode and elapsed time clamp, shared by all lanes.
   logic [LEVEL_W-1:0] levels;
   logic [TIME_W-1:0]  elapsed;
   logic [TIME_W-1:0]  delta;
   logic               tick_accept;
   logic               can_load;
   lane_cfg_type       lane_cfg;

   assign levels      = req_tdata[LEVEL_W-1:0];
   assign elapsed     = req_tdata[LEVEL_W +: TIME_W];
   assign delta       = (elapsed > step_limit_ff) ? step_subst_ff : elapsed;
   assign req_tready  = can_load;
   assign tick_accept = req_tvalid & can_load;
   assign lane_cfg.dbl_window = dbl_window_ff;
   assign lane_cfg.long_time  = long_time_ff;

   // One lane per button.
   lane_res_type [NUM_LANES-1:0] lane_res;
   logic [NUM_LANES-1:0]         lane_drag;

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      mbcc_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .step     (tick_accept),
         .now_down (levels[g]),
         .delta    (delta),
         .cfg      (lane_cfg),
         .res      (lane_res[g]),
         .dragging (lane_drag[g])
      );
   end

   // Merge the lanes and send the results one button at a time.
   logic [INDEX_W-1:0] out_index;
   lane_res_type       out_res;
   logic               out_any_drag;

   mbcc_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .load         (tick_accept),
      .lane_res     (lane_res),
      .lane_drag    (lane_drag),
      .can_load     (can_load),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_index    (out_index),
      .out_res      (out_res),
      .out_any_drag (out_any_drag),
      .out_last     (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, out_any_drag, out_res.held_time, out_res.button_state,
                       out_res.held_long, out_res.double_clicked, out_res.released,
                       out_res.pressed, out_res.is_down, out_index};

`ifndef SYNTH
   // The final item of a tick always carries the highest button index.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[INDEX_W-1:0] == INDEX_W'(NUM_LANES - 1)))
      else $error("last item of a tick carries the wrong button index");

   // A new tick only enters when the buffered one is gone or finishing.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && rsp_tvalid) |-> (rsp_tready && rsp_tlast))
      else $error("tick accepted over undelivered results");

   // Once a tick's results start, they keep coming until the last one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("result items of a tick stopped early");

   // A button cannot be pressed and released in the same tick.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[4] && rsp_tdata[5]))
      else $error("press and release flagged together");
`endif

endmodule

FILE: tb/sv/mbcc_click_checker.sv
`timescale 1ns / 1ps
// Checker for the mouse button click classifier: watches the tick, result and
// register write channels, predicts each per-button result item and compares.
// Depends on mbcc_pkg.
module mbcc_click_checker
   import mbcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [TIME_W-1:0]     csr_wdata,
   output int                    mismatch_count,
   output int                    results_outstanding
);

   localparam int PAD_LSB = 27;

   typedef struct packed {
      logic [INDEX_W-1:0] button_index;
      logic               is_down;
      logic               pressed;
      logic               released;
      logic               double_clicked;
      logic               held_long;
      logic [STATE_W-1:0] button_state;
      logic [TIME_W-1:0]  held_time;
      logic               any_dragging;
      logic               last_of_tick;
   } button_report_type;

   // Mirrored register values.
   logic [TIME_W-1:0] dbl_window, long_time, step_limit, step_subst;

   // Per-button history.
   logic              was_down      [NUM_LANES];
   logic [TIME_W-1:0] dbl_countdown [NUM_LANES];
   logic [TIME_W-1:0] hold_ms       [NUM_LANES];
   logic              long_hold     [NUM_LANES];

   button_report_type pending_reports [$];

   // Advances every button by one tick and queues the reports it produces.
   task automatic classify_tick(input logic [LEVEL_W-1:0] levels,
                                input logic [TIME_W-1:0] elapsed);
      logic [TIME_W-1:0] delta;
      logic [TIME_W:0]   hold_sum;
      logic              now, old, dbl_hit, dragging;
      button_report_type tick_reports [NUM_LANES];
      delta = (elapsed > step_limit) ? step_subst : elapsed;
      dragging = 1'b0;
      for (int b = 0; b < NUM_LANES; b++) begin
         old = was_down[b];
         now = levels[b];
         dbl_countdown[b] = (dbl_countdown[b] > delta) ? dbl_countdown[b] - delta : '0;
         if (old) dbl_countdown[b] = dbl_window;
         if (old) begin
            hold_sum = {1'b0, hold_ms[b]} + {1'b0, delta};
            hold_ms[b] = hold_sum[TIME_W] ? TIME_MAX : hold_sum[TIME_W-1:0];
            if (hold_ms[b] >= long_time) long_hold[b] = 1'b1;
         end else begin
            hold_ms[b] = '0;
            long_hold[b] = 1'b0;
         end
         dbl_hit = now && !old && (dbl_countdown[b] != '0);
         tick_reports[b].button_index   = INDEX_W'(b);
         tick_reports[b].is_down        = now;
         tick_reports[b].pressed        = now && !old;
         tick_reports[b].released       = !now && old;
         tick_reports[b].double_clicked = dbl_hit;
         tick_reports[b].held_long      = now && long_hold[b];
         tick_reports[b].held_time      = hold_ms[b];
         if (now) begin
            if (dbl_hit) begin
               tick_reports[b].button_state = ST_DOUBLE;
            end else begin
               tick_reports[b].button_state = ST_DRAGGED;
               dragging = 1'b1;
            end
         end else if (old) begin
            tick_reports[b].button_state = ST_RELEASED;
         end else begin
            tick_reports[b].button_state = ST_UP;
         end
         was_down[b] = now;
      end
      for (int b = 0; b < NUM_LANES; b++) begin
         tick_reports[b].any_dragging = dragging;
         tick_reports[b].last_of_tick = (b == NUM_LANES - 1);
         pending_reports.push_back(tick_reports[b]);
      end
   endtask

   function automatic string describe(button_report_type r);
      return $sformatf({"btn=%0d down=%b prs=%b rel=%b dbl=%b long=%b",
                        " st=%0d held=%0d drag=%b last=%b"},
                       r.button_index, r.is_down, r.pressed, r.released, r.double_clicked,
                       r.held_long, r.button_state, r.held_time, r.any_dragging,
                       r.last_of_tick);
   endfunction

   task automatic note_failure(input string what, input string exp_text, input string act_text);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%t: %s\n   expected %s\n   actual   %s", $realtime, what, exp_text, act_text);
      end
   endtask

   always @(posedge clock) begin : watch
      button_report_type expected_report, actual_report;
      if (reset) begin
         dbl_window = 16'd250;
         long_time  = 16'd700;
         step_limit = 16'd1000;
         step_subst = 16'd50;
         foreach (was_down[b]) begin
            was_down[b]      = 1'b0;
            dbl_countdown[b] = '0;
            hold_ms[b]       = '0;
            long_hold[b]     = 1'b0;
         end
         pending_reports.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_DBL_WINDOW: dbl_window = csr_wdata;
               CSR_LONG_TIME:  long_time  = csr_wdata;
               CSR_STEP_LIMIT: step_limit = csr_wdata;
               CSR_STEP_SUBST: step_subst = csr_wdata;
               default: ;
            endcase
         end
         // Results are taken before the new tick is predicted, so a stray
         // item can never be matched against this tick's expectations.
         if (rsp_tvalid && rsp_tready) begin
            actual_report = '{button_index:   rsp_tdata[2:0],
                              is_down:        rsp_tdata[3],
                              pressed:        rsp_tdata[4],
                              released:       rsp_tdata[5],
                              double_clicked: rsp_tdata[6],
                              held_long:      rsp_tdata[7],
                              button_state:   rsp_tdata[9:8],
                              held_time:      rsp_tdata[25:10],
                              any_dragging:   rsp_tdata[26],
                              last_of_tick:   rsp_tlast};
            if (pending_reports.size() == 0) begin
               note_failure("result item with nothing expected", "none",
                            describe(actual_report));
            end else begin
               expected_report = pending_reports.pop_front();
               if (actual_report !== expected_report ||
                   rsp_tdata[RSP_DATA_W-1:PAD_LSB] !== '0) begin
                  note_failure("result item mismatch", describe(expected_report),
                               $sformatf("%s pad=%0h", describe(actual_report),
                                         rsp_tdata[RSP_DATA_W-1:PAD_LSB]));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            classify_tick(req_tdata[LEVEL_W-1:0], req_tdata[LEVEL_W+TIME_W-1:LEVEL_W]);
         end
      end
      results_outstanding <= pending_reports.size();
   end

endmodule

FILE: tb/sv/mouse_button_click_classifier_tb.sv
`timescale 1ns / 1ps
// Testbench top for the mouse button click classifier: drives ticks and
// register writes, stalls the result side, and gives the verdict.
// Depends on mbcc_pkg, mbcc_click_checker and the block itself.
module mouse_button_click_classifier_tb;
   import mbcc_pkg::*;

   // Every input of the block starts at a known value.
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // buttons_down[7:0], elapsed_ms[23:8]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // button_index[2:0] .. any_dragging[26]
   logic                  rsp_tlast;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [TIME_W-1:0]     csr_wdata  = '0;

   int mismatch_count;
   int results_outstanding;

   // When calm is set, neither side inserts idle cycles, so the block runs
   // back to back at its full rate.
   bit                 calm = 1'b0;
   logic [LEVEL_W-1:0] last_levels = '0;
   int                 rsp_stall_left = 0;

   always #5 clock = ~clock;

   mouse_button_click_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   mbcc_click_checker checker_inst (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .rsp_tlast           (rsp_tlast),
      .csr_wr_en           (csr_wr_en),
      .csr_addr            (csr_addr),
      .csr_wdata           (csr_wdata),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   // Result side. After each accepted item the receiver draws how many cycles
   // it stalls before the next one. The stall lands on whichever of the eight
   // result items of a tick comes next, so over the run every position in a
   // tick sees back-pressure.
   always @(posedge clock) begin : result_side
      int stall_draw;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         stall_draw = calm ? 0 : $urandom_range(10);
         rsp_stall_left <= stall_draw;
         rsp_tready <= (stall_draw == 0);
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_tready <= (rsp_stall_left == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offers one tick after a random gap and holds it until the block takes it.
   // With no gap, tvalid simply stays high from the previous item, so it is
   // never lowered and raised within one time step.
   task automatic send_tick(input logic [LEVEL_W-1:0] levels, input logic [TIME_W-1:0] elapsed);
      int gap;
      gap = calm ? 0 : $urandom_range(10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {elapsed, levels};
      do @(posedge clock); while (!req_tready);
      last_levels = levels;
   endtask

   // Holds off the sender until every predicted result item has arrived.
   // The outstanding count is published from a register, so the first edge is
   // always waited out before it is trusted.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_outstanding != 0);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [TIME_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Registers are only rewritten once the block has gone idle.
   task automatic program_regs(input logic [TIME_W-1:0] window, input logic [TIME_W-1:0] hold,
                               input logic [TIME_W-1:0] limit, input logic [TIME_W-1:0] subst);
      drain_results();
      write_csr(CSR_DBL_WINDOW, window);
      write_csr(CSR_LONG_TIME, hold);
      write_csr(CSR_STEP_LIMIT, limit);
      write_csr(CSR_STEP_SUBST, subst);
      csr_wr_en <= 1'b0;
   endtask

   // One random step of mouse activity. Most steps look like real use: a few
   // buttons change level after a short interval, buttons stay held so the
   // hold time climbs toward a long press, or one button gets a quick
   // press-release-press gesture that should register as a double click.
   // The rest is noise over the full range of both fields.
   task automatic random_activity();
      int                 pick;
      logic [LEVEL_W-1:0] one_bit;
      pick = $urandom_range(99);
      if (pick < 15) begin
         one_bit = LEVEL_W'(1) << $urandom_range(NUM_LANES - 1);
         send_tick(last_levels | one_bit, TIME_W'($urandom_range(0, 150)));
         send_tick(last_levels & ~one_bit, TIME_W'($urandom_range(0, 150)));
         send_tick(last_levels | one_bit, TIME_W'($urandom_range(0, 150)));
      end else if (pick < 65) begin
         send_tick(last_levels ^ LEVEL_W'($urandom & $urandom & $urandom),
                   TIME_W'($urandom_range(0, 300)));
      end else if (pick < 85) begin
         send_tick(last_levels, TIME_W'($urandom_range(0, 1200)));
      end else begin
         send_tick(LEVEL_W'($urandom), TIME_W'($urandom));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset defaults: an idle tick, a press of all
      // buttons with no double-click pending (they go straight to dragged),
      // a hold with an elapsed time above the limit so the substitute is
      // used, an elapsed time exactly at the limit that makes the hold long,
      // a release, and a quick re-press that counts as a double click.
      send_tick(8'h00, 16'd0);
      send_tick(8'hFF, 16'd0);
      send_tick(8'hFF, 16'hFFFF);
      send_tick(8'hFF, 16'd1000);
      send_tick(8'h00, 16'd10);
      send_tick(8'hFF, 16'd100);
      send_tick(8'hAA, 16'd1001);
      send_tick(8'h55, 16'd0);
      send_tick(8'h00, 16'hFFFF);

      // All registers at zero: every nonzero elapsed time is replaced by a
      // zero substitute, no press can be a double click, and the long flag
      // sets on the first tick a button was already down.
      program_regs(16'd0, 16'd0, 16'd0, 16'd0);
      send_tick(8'h0F, 16'd5);
      send_tick(8'h0F, 16'd7);
      send_tick(8'h00, 16'd5);
      send_tick(8'h0F, 16'd0);

      // All registers at their maximum: nothing is ever substituted, the hold
      // time saturates after two long ticks, and the window is wide open.
      program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tick(8'hF0, 16'hFFFF);
      send_tick(8'hF0, 16'hFFFF);
      send_tick(8'hF0, 16'hFFFF);
      send_tick(8'h00, 16'd1);
      send_tick(8'hF0, 16'd1);
      send_tick(8'h00, 16'd0);

      // Random part in four settings. The third runs with no idling at all,
      // and the second pauses halfway until the block has fully drained.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: program_regs(16'd250, 16'd700, 16'd1000, 16'd50);
            1: program_regs(TIME_W'($urandom_range(0, 600)), TIME_W'($urandom_range(0, 2000)),
                            TIME_W'($urandom_range(0, 1500)), TIME_W'($urandom_range(0, 200)));
            2: program_regs(TIME_W'($urandom), TIME_W'($urandom),
                            TIME_W'($urandom), TIME_W'($urandom));
            default: program_regs(TIME_W'($urandom_range(100, 400)),
                                  TIME_W'($urandom_range(0, 500)),
                                  TIME_W'($urandom_range(0, 200)),
                                  TIME_W'($urandom_range(0, 100)));
         endcase
         calm = (phase == 2);
         for (int k = 0; k < 40; k++) begin
            if (phase == 1 && k == 20) drain_results();
            random_activity();
         end
      end
      calm = 1'b0;

      // Let the last results arrive, then watch a little longer for strays.
      drain_results();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("mouse_button_click_classifier verification clean");
      end else begin
         $display("mouse_button_click_classifier verification failed");
      end
      $finish;
   end

   // A correct run needs well under a third of this time.
   initial begin
      #(2_000_000);
      $display("mouse_button_click_classifier verification failed");
      $finish;
   end

endmodule
